// ===== hdl/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants, result codes and the group-to-byte function of the
// sextet frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

    // Frame start marker and the offset that turns a character into a sextet.
    localparam logic [7:0] START_CHAR  = 8'h23;
    localparam logic [7:0] OFFSET_CHAR = 8'h3D;

    // Last frame position that is counted; the counter saturates here.
    localparam logic [2:0] POS_SAT     = 3'd6;
    // First position whose delayed character is a payload character.
    localparam logic [2:0] POS_PAYLOAD = 3'd5;

    // Result kinds, carried on tuser.
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // End-of-frame status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SHORT    = 2'd1;
    localparam logic [1:0] ST_NO_START = 2'd2;
    localparam logic [1:0] ST_BAD_SUM  = 2'd3;

    // Results of one character, waiting to be sent out beat by beat.
    typedef struct packed {
        logic        has_bytes;
        logic        has_status;
        logic [23:0] bytes;
        logic [1:0]  status;
        logic [7:0]  addr;
        logic [7:0]  cmd;
    } t_bundle;

    // Four signed 9-bit sextets give three bytes, lowest byte first.
    // Shifts are arithmetic and each byte keeps its low eight bits.
    function automatic logic [23:0] group_bytes(input logic [8:0] a,
                                                input logic [8:0] b,
                                                input logic [8:0] c,
                                                input logic [8:0] d);
        logic signed [8:0] b_shr;
        logic signed [8:0] c_shr;
        logic [7:0]        byte0;
        logic [7:0]        byte1;
        logic [7:0]        byte2;
        b_shr = $signed(b) >>> 4;
        c_shr = $signed(c) >>> 2;
        byte0 = {a[5:0], 2'b00} | b_shr[7:0];
        byte1 = {b[3:0], 4'b0000} | c_shr[7:0];
        byte2 = {c[1:0], 6'b000000} | d[7:0];
        return {byte2, byte1, byte0};
    endfunction

endpackage

// ===== hdl/sextet_frame_decoder_top.sv =====
// ----------------------------------------------------------------------------
// sextet_frame_decoder_top
// Decodes a '#'-framed character stream of offset sextets into bytes and
// an end-of-frame status with address, command and checksum check.
// ----------------------------------------------------------------------------
//  Channel  | Direction | tdata                     | tuser | tlast
//  ---------+-----------+---------------------------+-------+---------------
//  s (in)   | input     | [7:0] rx_char             | -     | frame_end
//  m (out)  | output    | [7:0] payload_byte,       | kind  | last_of_run
//           |           | [9:8] status, [17:10]     |       |
//           |           | address_char, [25:18]     |       |
//           |           | command_char, [31:26] zero|       |
//
// A character is captured in an input register and decoded into a result
// register holding up to three bytes and one status beat; a character with
// beats waits until the last beat held there is sent. The output sends one
// beat per cycle while the receiver is ready, at most four per character.
// A character with no beats passes even while the result register drains.
// Reset is synchronous and active low; either side may stall at any time.
// ----------------------------------------------------------------------------
module sextet_frame_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_char
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [7:0] payload_byte, [9:8] status,
                                     // [17:10] address_char,
                                     // [25:18] command_char, [31:26] zero
    output logic        o_m_tuser,   // [0] kind
    output logic        o_m_tlast
);

    // Input register.
    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_in_end;

    // Frame decoding state.
    logic [2:0]  r_pos,   n_pos;
    logic [11:0] r_sum,   n_sum;
    logic [7:0]  r_d0,    n_d0;
    logic [7:0]  r_d1,    n_d1;
    logic [8:0]  r_g0,    n_g0;
    logic [8:0]  r_g1,    n_g1;
    logic [8:0]  r_g2,    n_g2;
    logic [1:0]  r_phase, n_phase;
    logic        r_start, n_start;
    logic [7:0]  r_addr,  n_addr;
    logic [7:0]  r_cmd,   n_cmd;

    // Result register and beat index.
    logic                r_b_valid;
    sfd_pkg::t_bundle    r_b;
    sfd_pkg::t_bundle    n_b;
    logic [1:0]          r_idx;

    logic        w_start_now;
    logic [8:0]  w_sextet;
    logic        w_full;
    logic        w_part;
    logic [8:0]  w_ga;
    logic [8:0]  w_gb;
    logic [8:0]  w_gc;
    logic [8:0]  w_gd;
    logic [7:0]  w_c1;
    logic [7:0]  w_c2;
    logic        w_any;
    logic        w_out_fire;
    logic        w_is_status;
    logic        w_out_last;
    logic        w_b_free;
    logic        w_proc;
    logic        w_accept;
    logic [7:0]  w_byte;

    // Decode of the registered character against the frame state.
    always_comb begin
        n_pos   = r_pos;
        n_sum   = r_sum;
        n_g0    = r_g0;
        n_g1    = r_g1;
        n_g2    = r_g2;
        n_phase = r_phase;
        n_start = r_start;
        n_addr  = r_addr;
        n_cmd   = r_cmd;
        w_full  = 1'b0;
        w_part  = 1'b0;
        w_ga    = r_g0;
        w_gb    = r_g1;
        w_gc    = r_g2;
        w_gd    = 9'd0;
        w_c1    = 8'd0;
        w_c2    = 8'd0;
        n_b.has_bytes  = 1'b0;
        n_b.has_status = r_in_end;
        n_b.bytes      = 24'd0;
        n_b.status     = sfd_pkg::ST_OK;
        n_b.addr       = 8'd0;
        n_b.cmd        = 8'd0;

        w_sextet    = {1'b0, r_d1} - {1'b0, sfd_pkg::OFFSET_CHAR};
        w_start_now = r_start;

        // Header characters.
        if (r_pos == 3'd0) begin
            n_start     = (r_in_char == sfd_pkg::START_CHAR);
            w_start_now = n_start;
        end else if (r_pos == 3'd1) begin
            n_addr = r_in_char;
        end else if (r_pos == 3'd2) begin
            n_cmd = r_in_char;
        end

        // The character leaving the delay line joins the sum and, from the payload position on, the group.
        if (r_pos >= 3'd2) begin
            n_sum = r_sum + {4'd0, r_d1};
            if (r_pos >= sfd_pkg::POS_PAYLOAD) begin
                if (r_phase == 2'd3) begin
                    w_full  = 1'b1;
                    w_gd    = w_sextet;
                    n_phase = 2'd0;
                end else begin
                    case (r_phase)
                        2'd0:    n_g0 = w_sextet;
                        2'd1:    n_g1 = w_sextet;
                        default: n_g2 = w_sextet;
                    endcase
                    n_phase = r_phase + 2'd1;
                end
            end
        end

        n_d1 = r_d0;
        n_d0 = r_in_char;

        if (!r_in_end) begin
            n_pos = (r_pos < sfd_pkg::POS_SAT) ? r_pos + 3'd1 : sfd_pkg::POS_SAT;
        end else begin
            // Zero-filled partial group at the end of the frame.
            if (n_phase != 2'd0) begin
                w_part = 1'b1;
                w_ga   = n_g0;
                w_gb   = (n_phase > 2'd1) ? n_g1 : 9'd0;
                w_gc   = (n_phase > 2'd2) ? n_g2 : 9'd0;
                w_gd   = 9'd0;
            end
            // Checksum characters expected from the running sum.
            w_c1 = sfd_pkg::OFFSET_CHAR + {2'd0, n_sum[11:6]};
            w_c2 = sfd_pkg::OFFSET_CHAR + {2'd0, n_sum[5:0]};
            if (r_pos < sfd_pkg::POS_PAYLOAD) begin
                n_b.status = sfd_pkg::ST_SHORT;
            end else if (!w_start_now) begin
                n_b.status = sfd_pkg::ST_NO_START;
            end else if (w_c1 != r_d0 || w_c2 != r_in_char) begin
                n_b.status = sfd_pkg::ST_BAD_SUM;
            end else begin
                n_b.status = sfd_pkg::ST_OK;
            end
            n_b.addr = n_addr;
            n_b.cmd  = n_cmd;
            // Back to the reset state for the next frame.
            n_pos   = 3'd0;
            n_sum   = 12'd0;
            n_d0    = 8'd0;
            n_d1    = 8'd0;
            n_g0    = 9'd0;
            n_g1    = 9'd0;
            n_g2    = 9'd0;
            n_phase = 2'd0;
            n_start = 1'b0;
            n_addr  = 8'd0;
            n_cmd   = 8'd0;
        end

        // Bytes only come out of frames that opened with the start marker.
        n_b.has_bytes = (w_full || w_part) && w_start_now;
        n_b.bytes     = sfd_pkg::group_bytes(w_ga, w_gb, w_gc, w_gd);
    end

    // Handshake and beat sequencing.
    always_comb begin
        w_any       = n_b.has_bytes || n_b.has_status;
        w_out_fire  = r_b_valid && i_m_tready;
        w_is_status = r_b.has_status && (!r_b.has_bytes || r_idx == 2'd3);
        w_out_last  = r_b.has_status ? w_is_status : (r_idx == 2'd2);
        w_b_free    = !r_b_valid || (w_out_fire && w_out_last);
        w_proc      = r_in_valid && (w_b_free || !w_any);
        w_accept    = i_s_tvalid && o_s_tready;
    end

    assign o_s_tready = !r_in_valid || w_proc;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_char <= i_s_tdata;
            r_in_end  <= i_s_tlast;
        end
    end

    // Frame state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 3'd0;
            r_sum   <= 12'd0;
            r_d0    <= 8'd0;
            r_d1    <= 8'd0;
            r_g0    <= 9'd0;
            r_g1    <= 9'd0;
            r_g2    <= 9'd0;
            r_phase <= 2'd0;
            r_start <= 1'b0;
            r_addr  <= 8'd0;
            r_cmd   <= 8'd0;
        end else if (w_proc) begin
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_d0    <= n_d0;
            r_d1    <= n_d1;
            r_g0    <= n_g0;
            r_g1    <= n_g1;
            r_g2    <= n_g2;
            r_phase <= n_phase;
            r_start <= n_start;
            r_addr  <= n_addr;
            r_cmd   <= n_cmd;
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_idx     <= 2'd0;
        end else if (w_proc && w_any) begin
            r_b_valid <= 1'b1;
            r_idx     <= n_b.has_bytes ? 2'd0 : 2'd3;
        end else if (w_out_fire && w_out_last) begin
            r_b_valid <= 1'b0;
        end else if (w_out_fire) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && w_any) begin
            r_b <= n_b;
        end
    end

    // Output beat selection.
    always_comb begin
        case (r_idx)
            2'd0:    w_byte = r_b.bytes[7:0];
            2'd1:    w_byte = r_b.bytes[15:8];
            default: w_byte = r_b.bytes[23:16];
        endcase
    end

    assign o_m_tvalid = r_b_valid;
    assign o_m_tuser  = w_is_status ? sfd_pkg::KIND_STATUS : sfd_pkg::KIND_BYTE;
    assign o_m_tlast  = w_out_last;
    assign o_m_tdata  = w_is_status ?
                        {6'd0, r_b.cmd, r_b.addr, r_b.status, 8'd0} :
                        {24'd0, w_byte};

endmodule
